/* rtl/ctbl_pkg.sv */
// shared types, constants and codes for the cursor text buffer list
package ctbl_pkg;

  localparam int POOL_NODES = 4096;
  localparam int NODE_COUNT = POOL_NODES + 1;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int ADDR_W     = $clog2(POOL_NODES);
  localparam int CHAR_W     = 8;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic  ok;
    node_t idx;
  } link_t;

  localparam link_t LINK_NULL = '{ok: 1'b0, idx: '0};

  typedef enum logic [REQ_W-1:0] {
    REQ_LEFT   = 3'd0,
    REQ_RIGHT  = 3'd1,
    REQ_BACK   = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_PATCH,
    S_CHAR,
    S_POST
  } state_t;

  typedef struct packed {
    logic  rd_en;
    node_t rd_node;
    logic  prev_we;
    node_t prev_node;
    link_t prev_data;
    logic  next_we;
    node_t next_node;
    link_t next_data;
    logic  char_we;
    node_t char_node;
    char_t char_data;
  } store_cmd_t;

  typedef struct packed {
    link_t prev;
    link_t next;
    char_t chr;
  } store_rsp_t;

endpackage

/* rtl/ctbl_if.sv */
// request and result channel interfaces
interface ctbl_req_if;
  import ctbl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [CHAR_W-1:0]     char_value;
  modport source (output valid, output req_type, output char_value, input ready);
  modport sink   (input valid, input req_type, input char_value, output ready);
endinterface

interface ctbl_res_if;
  import ctbl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [CHAR_W-1:0]     read_char;
  logic                  read_end;
  modport source (output valid, output status, output read_char, output read_end,
                  input ready);
  modport sink   (input valid, input status, input read_char, input read_end,
                  output ready);
endinterface

/* rtl/ctbl_store.sv */
// node pool memories: characters, back links and forward links, head node in flops
module ctbl_store (
  input  logic                clk,
  input  logic                rst,
  input  ctbl_pkg::store_cmd_t cmd,
  output ctbl_pkg::store_rsp_t rsp
);
  import ctbl_pkg::*;

  link_t prev_mem [POOL_NODES];
  link_t next_mem [POOL_NODES];
  char_t char_mem [POOL_NODES];

  // head node has no character and never a back link
  link_t head_next;
  link_t head_rd;
  link_t prev_rd;
  link_t next_rd;
  char_t char_rd;
  logic  rd_head;

  function automatic logic [ADDR_W-1:0] node_addr(node_t n);
    node_t t;
    t = n - NODE_W'(1);
    return t[ADDR_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head_next <= LINK_NULL;
    end else if (cmd.next_we && cmd.next_node == '0) begin
      head_next <= cmd.next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prev_we && cmd.prev_node != '0) begin
      prev_mem[node_addr(cmd.prev_node)] <= cmd.prev_data;
    end
    if (cmd.next_we && cmd.next_node != '0) begin
      next_mem[node_addr(cmd.next_node)] <= cmd.next_data;
    end
    if (cmd.char_we && cmd.char_node != '0) begin
      char_mem[node_addr(cmd.char_node)] <= cmd.char_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_head <= (cmd.rd_node == '0);
      head_rd <= head_next;
      if (cmd.rd_node != '0) begin
        prev_rd <= prev_mem[node_addr(cmd.rd_node)];
        next_rd <= next_mem[node_addr(cmd.rd_node)];
        char_rd <= char_mem[node_addr(cmd.rd_node)];
      end
    end
  end

  always_comb begin
    rsp.prev = rd_head ? LINK_NULL : prev_rd;
    rsp.next = rd_head ? head_rd : next_rd;
    rsp.chr  = char_rd;
  end

endmodule

/* rtl/cursor_text_buffer_list.sv */
// cursor text buffer list: linked-list line editor with a sequencer over the node store
//
//   channel | dir | fields                       | handshake
//   req     | in  | req_type, char_value         | valid/ready
//   res     | out | status, read_char, read_end  | valid/ready
//
// an item runs from the idle state that takes it to the post state: backspaces
// at the head, inserts into a full pool and unknown types go straight to post;
// left, right, backspace and a read at the end read one node in fetch; inserts read
// it, fill the new node and then patch links; other reads walk a link and then a character.
// reset is synchronous and needs no clearing pass: only nodes below the free
// counter are ever read, and the head node's link lives in a flop.
// one result waits in the output register while the next item is taken; the next
// finished item holds in the post cycle until that register is accepted.
module cursor_text_buffer_list (
  input logic        clk,
  input logic        rst,
  ctbl_req_if.sink   req,
  ctbl_res_if.source res
);
  import ctbl_pkg::*;

  state_t     state;
  state_t     state_next;
  req_t       op;
  req_t       op_next;
  char_t      ch;
  char_t      ch_next;
  node_t      cursor;
  node_t      cursor_next;
  node_t      read_ptr;
  node_t      read_ptr_next;
  node_t      free_cnt;
  node_t      free_cnt_next;
  link_t      succ;
  link_t      succ_next;
  status_t    res_status;
  status_t    res_status_next;
  char_t      res_char;
  char_t      res_char_next;
  logic       res_end;
  logic       res_end_next;
  logic       out_valid;
  status_t    out_status;
  char_t      out_char;
  logic       out_end;
  logic       out_free;
  logic       pool_full;
  store_cmd_t cmd;
  store_rsp_t rsp;

  ctbl_store u_store (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  assign pool_full = free_cnt > NODE_W'(POOL_NODES);
  assign out_free  = !out_valid || res.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req_t'(req.req_type))
            REQ_LEFT, REQ_RIGHT, REQ_READ: state_next = S_FETCH;
            REQ_BACK:   state_next = (cursor == '0) ? S_POST : S_FETCH;
            REQ_INSERT: state_next = pool_full ? S_POST : S_FETCH;
            default:    state_next = S_POST;
          endcase
        end
      end
      S_FETCH: begin
        case (op)
          REQ_INSERT: state_next = S_PATCH;
          REQ_READ:   state_next = rsp.next.ok ? S_CHAR : S_POST;
          default:    state_next = S_POST;
        endcase
      end
      S_PATCH: state_next = S_POST;
      S_CHAR:  state_next = S_POST;
      S_POST:  state_next = out_free ? S_IDLE : S_POST;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready       = (state == S_IDLE);
    cmd             = '0;
    op_next         = op;
    ch_next         = ch;
    cursor_next     = cursor;
    read_ptr_next   = read_ptr;
    free_cnt_next   = free_cnt;
    succ_next       = succ;
    res_status_next = res_status;
    res_char_next   = res_char;
    res_end_next    = res_end;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next         = req_t'(req.req_type);
          ch_next         = req.char_value;
          res_status_next = STAT_DONE;
          res_char_next   = '0;
          res_end_next    = 1'b0;
          cmd.rd_node     = cursor;
          case (req_t'(req.req_type))
            REQ_LEFT, REQ_RIGHT: cmd.rd_en = 1'b1;
            REQ_BACK: begin
              if (cursor == '0) res_status_next = STAT_IGNORED;
              else cmd.rd_en = 1'b1;
            end
            REQ_INSERT: begin
              if (pool_full) res_status_next = STAT_FULL;
              else cmd.rd_en = 1'b1;
            end
            REQ_READ: begin
              cmd.rd_en   = 1'b1;
              cmd.rd_node = read_ptr;
            end
            default: res_status_next = STAT_IGNORED;
          endcase
        end
      end
      S_FETCH: begin
        case (op)
          REQ_LEFT: begin
            if (rsp.prev.ok) cursor_next = rsp.prev.idx;
            else res_status_next = STAT_IGNORED;
          end
          REQ_RIGHT: begin
            if (rsp.next.ok) cursor_next = rsp.next.idx;
            else res_status_next = STAT_IGNORED;
          end
          REQ_BACK: begin
            if (rsp.prev.ok) begin
              // unlink the cursor node; it keeps its own links
              cmd.next_we   = 1'b1;
              cmd.next_node = rsp.prev.idx;
              cmd.next_data = rsp.next;
              cmd.prev_we   = rsp.next.ok;
              cmd.prev_node = rsp.next.idx;
              cmd.prev_data = '{ok: 1'b1, idx: rsp.prev.idx};
              cursor_next   = rsp.prev.idx;
            end else begin
              res_status_next = STAT_IGNORED;
            end
          end
          REQ_INSERT: begin
            // fill the new node, patch its neighbors next cycle
            cmd.char_we   = 1'b1;
            cmd.char_node = free_cnt;
            cmd.char_data = ch;
            cmd.prev_we   = 1'b1;
            cmd.prev_node = free_cnt;
            cmd.prev_data = '{ok: 1'b1, idx: cursor};
            cmd.next_we   = 1'b1;
            cmd.next_node = free_cnt;
            cmd.next_data = rsp.next;
            succ_next     = rsp.next;
          end
          REQ_READ: begin
            if (rsp.next.ok) begin
              read_ptr_next = rsp.next.idx;
              cmd.rd_en     = 1'b1;
              cmd.rd_node   = rsp.next.idx;
            end else begin
              read_ptr_next = '0;
              res_end_next  = 1'b1;
            end
          end
          default: res_status_next = STAT_IGNORED;
        endcase
      end
      S_PATCH: begin
        cmd.next_we   = 1'b1;
        cmd.next_node = cursor;
        cmd.next_data = '{ok: 1'b1, idx: free_cnt};
        cmd.prev_we   = succ.ok;
        cmd.prev_node = succ.idx;
        cmd.prev_data = '{ok: 1'b1, idx: free_cnt};
        cursor_next   = free_cnt;
        free_cnt_next = free_cnt + NODE_W'(1);
      end
      S_CHAR: res_char_next = rsp.chr;
      S_POST: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cursor   <= '0;
      read_ptr <= '0;
      free_cnt <= NODE_W'(1);
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      read_ptr <= read_ptr_next;
      free_cnt <= free_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    ch         <= ch_next;
    succ       <= succ_next;
    res_status <= res_status_next;
    res_char   <= res_char_next;
    res_end    <= res_end_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_POST && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_POST && out_free) begin
      out_status <= res_status;
      out_char   <= res_char;
      out_end    <= res_end;
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_status;
  assign res.read_char = out_char;
  assign res.read_end  = out_end;

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= NODE_W'(NODE_COUNT))
    else $error("free counter ran past the pool");

  a_cursor_alloc: assert property (@(posedge clk) disable iff (rst)
    cursor < free_cnt)
    else $error("cursor on a node not yet handed out");

  a_read_alloc: assert property (@(posedge clk) disable iff (rst)
    read_ptr < free_cnt)
    else $error("read pointer on a node not yet handed out");

  a_char_new_node: assert property (@(posedge clk) disable iff (rst)
    cmd.char_we |-> (cmd.char_node == free_cnt && !pool_full))
    else $error("character written outside the next free node");

  a_post_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished item not posted to the output register");

endmodule
